### rtl/msort_pkg.sv
// Shared types and state encoding for the merge sorter.
package msort_pkg;

	// Width of the value fields on both channels
	localparam int unsigned ValueW = 32;

	// One input transfer
	typedef struct packed {
		logic signed [ValueW-1:0] value;
		logic                     last_in;
	} in_item_t;

	// One result transfer
	typedef struct packed {
		logic signed [ValueW-1:0] sorted_value;
		logic                     last_out;
		logic                     overflow;
	} out_item_t;

	// Per-cycle command to every cell of the row
	typedef struct packed {
		logic insert;    // place the broadcast value in order
		logic shift_out; // move every entry one cell toward the head
	} cell_ctl_t;

	// Controller states: collect a set, then stream it out
	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

endpackage

### rtl/msort_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface msort_in_if;
	import msort_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface msort_out_if;
	import msort_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/msort_cell.sv
// One cell of the sorting row: holds a single value and trades with its neighbors.
module msort_cell #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  msort_pkg::cell_ctl_t   ctl,
	input  logic [DATA_WIDTH-1:0]  ins_val,
	input  logic                   prev_valid,
	input  logic [DATA_WIDTH-1:0]  prev_val,
	input  logic                   prev_gt,
	input  logic                   next_valid,
	input  logic [DATA_WIDTH-1:0]  next_val,
	output logic                   valid,
	output logic [DATA_WIDTH-1:0]  val,
	output logic                   gt
);
	import msort_pkg::*;

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] val_q;

	// Strictly greater keeps equal values in arrival order
	assign gt    = valid_q && ($signed(ins_val) < $signed(val_q));
	assign valid = valid_q;
	assign val   = val_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= valid_q | prev_valid;
		end else if (ctl.shift_out) begin
			valid_q <= next_valid;
		end
	end

	// Insert: take the left neighbor when it moves right, else the new value
	// where it belongs; drain: take the right neighbor
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || !valid_q) begin
				val_q <= ins_val;
			end
		end else if (ctl.shift_out) begin
			val_q <= next_val;
		end
	end

endmodule

### rtl/merge_sorter_top.sv
// Stable ascending sorter built from a row of compare-and-shift cells.
// Fill: one input per cycle; each value that fits drops into its sorted place at once.
// After the transfer marked last, the first result is offered on the next cycle and
// the set streams out at one result per cycle while the result channel is ready.
// Input ready is low while a set drains. Reset clears all cell valid bits,
// the overflow flag and the controller; cell payloads are not reset.
module merge_sorter_top #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	msort_in_if.sink    din,
	msort_out_if.source dout
);
	import msort_pkg::*;

	state_t                state_q;
	state_t                state_d;
	logic                  dropped_q;
	cell_ctl_t             ctl;
	logic                  in_xfer;
	logic                  out_xfer;
	logic                  full;
	logic                  final_out;
	logic signed [63:0]    in_ext;
	logic signed [63:0]    out_ext;
	logic [DATA_WIDTH-1:0] ins_val;

	logic                  vld [DEPTH];
	logic [DATA_WIDTH-1:0] vals [DEPTH];
	logic                  gts [DEPTH];

	// Sign-extend the input, then keep the stored width
	assign in_ext  = 64'($signed(din.data.value));
	assign ins_val = in_ext[DATA_WIDTH-1:0];

	assign in_xfer   = din.valid && din.ready;
	assign out_xfer  = dout.valid && dout.ready;
	assign full      = vld[DEPTH-1];
	assign final_out = !vld[1];

	// Row of cells; the head cell always sees an occupied left neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  p_valid;
		logic [DATA_WIDTH-1:0] p_val;
		logic                  p_gt;
		logic                  n_valid;
		logic [DATA_WIDTH-1:0] n_val;

		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_val   = '0;
			assign p_gt    = 1'b0;
		end else begin : g_body
			assign p_valid = vld[i-1];
			assign p_val   = vals[i-1];
			assign p_gt    = gts[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_val   = '0;
		end else begin : g_link
			assign n_valid = vld[i+1];
			assign n_val   = vals[i+1];
		end

		msort_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.ins_val    (ins_val),
			.prev_valid (p_valid),
			.prev_val   (p_val),
			.prev_gt    (p_gt),
			.next_valid (n_valid),
			.next_val   (n_val),
			.valid      (vld[i]),
			.val        (vals[i]),
			.gt         (gts[i])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (in_xfer && din.data.last_in) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_xfer && final_out) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	// Outputs and cell commands
	always_comb begin
		din.ready     = 1'b0;
		dout.valid    = 1'b0;
		ctl.insert    = 1'b0;
		ctl.shift_out = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				din.ready  = 1'b1;
				ctl.insert = din.valid && !full;
			end
			ST_DRAIN: begin
				dout.valid    = 1'b1;
				ctl.shift_out = dout.ready;
			end
			default: ;
		endcase
	end

	// Result payload comes straight from the head cell
	assign out_ext                = 64'($signed(vals[0]));
	assign dout.data.sorted_value = out_ext[31:0];
	assign dout.data.last_out     = final_out;
	assign dout.data.overflow     = dropped_q;

	// Hold state and the overflow flag for the current set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && full) begin
				dropped_q <= 1'b1;
			end else if (out_xfer && final_out) begin
				dropped_q <= 1'b0;
			end
		end
	end

	// Never take input and offer a result in the same cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(din.ready && dout.valid))
		else $error("input and output active together");

	// A draining row always has a head entry
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> vld[0])
		else $error("result offered from empty row");

	// Occupied cells stay packed toward the head; checked for the first two cells
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		vld[1] |-> vld[0])
		else $error("hole at head of row");

	// Final result empties the row and reopens input
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && final_out |=> din.ready && !vld[0] && !dropped_q)
		else $error("row not cleared after final result");

endmodule

### bench/tb_merge_sorter_top.sv
// Self-checking testbench for the merge sorter: sends value sets and checks the sorted output.
`timescale 1ns / 1ps

module tb_merge_sorter_top;
	import msort_pkg::*;

	localparam int unsigned StoreDepth = 64;
	localparam logic signed [ValueW-1:0] ValMin = 32'sh8000_0000;
	localparam logic signed [ValueW-1:0] ValMax = 32'sh7FFF_FFFF;
	localparam int unsigned IdlePct = 17;
	localparam int unsigned RandomItems = 130;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;          // no idling on either side while set

	msort_in_if  din_if();
	msort_out_if dout_if();

	merge_sorter_top #(
		.DEPTH     (StoreDepth),
		.DATA_WIDTH(ValueW)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if)
	);

	// Predictor state: values held for the open set and the sorted results still owed
	logic signed [ValueW-1:0] held_values[$];
	bit                       held_dropped;
	out_item_t                sorted_expect[$];
	int unsigned              mismatch_count;
	int unsigned              items_sent;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Record a mismatch; print only the first few
	task automatic note_failure(input string what, input longint want, input longint got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
		end
	endtask

	// Hold an accepted value and, on the last one, emit the set in stable ascending order
	task automatic predict_sorted_set(input logic signed [ValueW-1:0] v, input logic last);
		logic signed [ValueW-1:0] ordered[$];
		int                       pos;
		out_item_t                res;
		if (held_values.size() < StoreDepth) begin
			held_values.push_back(v);
		end else begin
			held_dropped = 1'b1;
		end
		if (last) begin
			// insert after every equal value to keep arrival order
			foreach (held_values[i]) begin
				pos = ordered.size();
				while (pos > 0 && ordered[pos-1] > held_values[i]) begin
					pos--;
				end
				ordered.insert(pos, held_values[i]);
			end
			foreach (ordered[k]) begin
				res.sorted_value = ordered[k];
				res.last_out     = (k == ordered.size() - 1);
				res.overflow     = held_dropped;
				sorted_expect.push_back(res);
			end
			held_values.delete();
			held_dropped = 1'b0;
		end
	endtask

	// Drive one input transfer, idling at random before it
	task automatic send_value(input logic signed [ValueW-1:0] v, input logic last);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IdlePct) begin
			din_if.valid <= 1'b0;
			@(negedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.data  <= '{value: v, last_in: last};
		do @(posedge clk); while (!din_if.ready);
		items_sent++;
		predict_sorted_set(v, last);
	endtask

	// Mix of wide random values, clustered small values (duplicates) and extremes
	function automatic logic signed [ValueW-1:0] random_value();
		int unsigned pick;
		int          small_v;
		pick = $urandom_range(99);
		if (pick < 40) begin
			return $urandom();
		end else if (pick < 75) begin
			small_v = int'($urandom_range(8)) - 4;
			return small_v;
		end
		case ($urandom_range(5))
			0: return ValMin;
			1: return ValMax;
			2: return ValMin + 1;
			3: return ValMax - 1;
			4: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic send_set(input int unsigned size);
		for (int unsigned i = 1; i <= size; i++) begin
			send_value(random_value(), i == size);
		end
	endtask

	// Sets of one value, including both extremes
	task automatic test_single_value();
		send_value(ValMin, 1'b1);
		send_value(ValMax, 1'b1);
		send_value('0, 1'b1);
	endtask

	// Extremes and alternating bit patterns in one set
	task automatic test_extremes();
		send_value(ValMax, 1'b0);
		send_value(ValMin, 1'b0);
		send_value('0, 1'b0);
		send_value('1, 1'b0);
		send_value(32'sh5555_5555, 1'b0);
		send_value(32'shAAAA_AAAA, 1'b0);
		send_value(ValMin + 1, 1'b0);
		send_value(ValMax - 1, 1'b0);
		send_value(32'sd1, 1'b1);
	endtask

	// Repeated values, including a set of all-equal values
	task automatic test_duplicates();
		send_value(32'sd5, 1'b0);
		send_value(-32'sd3, 1'b0);
		send_value(32'sd5, 1'b0);
		send_value(32'sd5, 1'b0);
		send_value(-32'sd3, 1'b1);
		send_value(ValMin, 1'b0);
		send_value(ValMin, 1'b0);
		send_value(ValMin, 1'b1);
	endtask

	// Exactly full store, overflow dropping the last value, then the last six, then a clean set
	task automatic test_store_limits();
		steady = 1'b1;
		send_set(StoreDepth);
		steady = 1'b0;
		send_set(StoreDepth + 1);
		send_set(StoreDepth + 6);
		send_set(3);
	endtask

	// Random set sizes, mostly small, with occasional near-full and overflowing sets
	task automatic test_random_sets();
		int unsigned start_count;
		int unsigned set_index;
		int unsigned pick;
		int unsigned size;
		start_count = items_sent;
		set_index   = 0;
		while (items_sent - start_count < RandomItems) begin
			steady = (set_index >= 2 && set_index < 7);
			pick   = $urandom_range(99);
			if (pick < 80) begin
				size = $urandom_range(12, 1);
			end else if (pick < 90) begin
				size = $urandom_range(40, 13);
			end else if (pick < 95) begin
				size = $urandom_range(StoreDepth, StoreDepth - 4);
			end else begin
				size = $urandom_range(StoreDepth + 6, StoreDepth + 1);
			end
			send_set(size);
			set_index++;
		end
		steady = 1'b0;
	endtask

	// Stall the result channel at random
	initial begin
		dout_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			dout_if.ready <= steady || ($urandom_range(99) >= IdlePct);
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			got = dout_if.data;
			if (sorted_expect.size() == 0) begin
				note_failure("result with none expected, sorted_value", 0,
					longint'($signed(got.sorted_value)));
			end else begin
				want = sorted_expect.pop_front();
				if (got.sorted_value !== want.sorted_value) begin
					note_failure("sorted_value", longint'($signed(want.sorted_value)),
						longint'($signed(got.sorted_value)));
				end
				if (got.last_out !== want.last_out) begin
					note_failure("last_out", want.last_out, got.last_out);
				end
				if (got.overflow !== want.overflow) begin
					note_failure("overflow", want.overflow, got.overflow);
				end
			end
		end
	end

	// Main sequence
	initial begin
		arst_n         = 1'b0;
		din_if.valid   = 1'b0;
		din_if.data    = '0;
		steady         = 1'b0;
		held_dropped   = 1'b0;
		mismatch_count = 0;
		items_sent     = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_value();
		test_extremes();
		test_duplicates();
		test_store_limits();
		test_random_sets();

		@(negedge clk);
		din_if.valid <= 1'b0;
		while (sorted_expect.size() != 0) begin
			@(posedge clk);
		end
		// let any stray result show up
		repeat (3 * StoreDepth) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
rtl/msort_pkg.sv
rtl/msort_if.sv
rtl/msort_cell.sv
rtl/merge_sorter_top.sv
bench/tb_merge_sorter_top.sv
